/* rtl/rbst_pkg.sv */
// shared types and constants for the ray versus box slab test
package rbst_pkg;

	localparam int QUOT_W     = 33;
	localparam int DIV_STAGES = QUOT_W;
	localparam int MAG_W      = 33;
	localparam int DEN_W      = 32;
	localparam int REM_HI_W   = 16;

	localparam logic signed [31:0] T_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] T_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} ray_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] entry_distance;
	} res_t;

	// per-item info that rides alongside the dividers
	typedef struct packed {
		logic       valid;
		logic [5:0] neg;
		logic [5:0] ovf;
		logic [2:0] par;
		logic       par_ok;
	} side_t;

endpackage

/* rtl/rbst_div.sv */
// pipelined unsigned restoring divider, one quotient bit per stage
module rbst_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rbst_pkg::REM_HI_W-1:0] num_hi,
	input  logic [rbst_pkg::QUOT_W-1:0]   num_lo,
	input  logic [rbst_pkg::DEN_W-1:0]    den,
	output logic [rbst_pkg::QUOT_W-1:0]   quot
);
	import rbst_pkg::*;

	logic [DEN_W-1:0]  rem_s  [DIV_STAGES];
	logic [QUOT_W-1:0] quo_s  [DIV_STAGES];
	logic [QUOT_W-1:0] num_s  [DIV_STAGES];
	logic [DEN_W-1:0]  den_s  [DIV_STAGES];

	// each stage shifts in one dividend bit and subtracts when it fits
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DEN_W-1:0]  rem_in;
		logic [QUOT_W-1:0] quo_in;
		logic [QUOT_W-1:0] num_in;
		logic [DEN_W-1:0]  den_in;
		logic [DEN_W:0]    trial;
		logic              fits;

		if (k == 0) begin : g_first
			assign rem_in = {{(DEN_W-REM_HI_W){1'b0}}, num_hi};
			assign quo_in = '0;
			assign num_in = num_lo;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign num_in = num_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign trial = {rem_in, num_in[QUOT_W-1-k]};
		assign fits  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fits ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
				quo_s[k] <= {quo_in[QUOT_W-2:0], fits};
				num_s[k] <= num_in;
				den_s[k] <= den_in;
			end
		end
	end

	assign quot = quo_s[DIV_STAGES-1];

endmodule

/* rtl/ray_box_slab_test.sv */
// top level of the ray versus axis-aligned box slab test
// One request is taken every cycle unless the result side stalls, and one result
// comes out for each, in order. The pipeline has one input stage, 33 divider stages
// (one quotient bit of each of the six plane parameters per stage), one saturate and
// order stage and one interval stage that is also the output register. A stall on
// the result side freezes the whole pipeline, so nothing is lost or repeated.
module ray_box_slab_test (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ray_valid,
	output logic            ray_stall,
	input  rbst_pkg::ray_t  ray,
	output logic            res_valid,
	input  logic            res_stall,
	output rbst_pkg::res_t  res
);
	import rbst_pkg::*;

	logic adv;
	assign adv       = !res_stall || !res_valid;
	assign ray_stall = !adv;

	// lane order: min x, min y, min z, max x, max y, max z
	logic signed [31:0] org [3];
	logic signed [31:0] dir [3];
	logic signed [31:0] bnd [6];
	assign org = '{ray.origin_x, ray.origin_y, ray.origin_z};
	assign dir = '{ray.dir_x, ray.dir_y, ray.dir_z};
	assign bnd = '{ray.box_min_x, ray.box_min_y, ray.box_min_z,
		ray.box_max_x, ray.box_max_y, ray.box_max_z};

	// input stage: differences, magnitudes, signs, overflow and parallel checks
	logic [MAG_W-1:0] mag_s1 [6];
	logic [DEN_W-1:0] den_s1 [6];
	side_t            side_s1;
	side_t            side_d;

	always_comb begin
		logic signed [32:0] diff;
		logic [MAG_W-1:0]   mag;
		logic [DEN_W-1:0]   dm;
		side_d.valid  = ray_valid;
		side_d.par_ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			side_d.par[a] = dir[a] == 32'sd0;
			if (side_d.par[a] && (org[a] < bnd[a] || org[a] > bnd[a+3]))
				side_d.par_ok = 1'b0;
		end
		for (int l = 0; l < 6; l++) begin
			diff = 33'(bnd[l]) - 33'(org[l%3]);
			mag  = diff[32] ? MAG_W'(-diff) : MAG_W'(diff);
			dm   = dir[l%3][31] ? DEN_W'(-dir[l%3]) : DEN_W'(dir[l%3]);
			side_d.neg[l] = (diff[32] != dir[l%3][31]) && (mag != '0);
			side_d.ovf[l] = {16'b0, mag[32:17]} >= dm;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 6; l++) begin
				mag_s1[l] <= MAG_W'(bnd[l]) - MAG_W'(org[l%3]);
				den_s1[l] <= dir[l%3][31] ? DEN_W'(-dir[l%3]) : DEN_W'(dir[l%3]);
			end
		end
	end

	// signed difference is recomputed above into raw bits; take magnitude here
	logic [MAG_W-1:0] abs_s1 [6];
	logic [5:0]       dneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1 <= side_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 6; l++)
				dneg_s1[l] <= (33'(bnd[l]) - 33'(org[l%3])) >> 32 != 33'd0;
		end
	end

	always_comb begin
		for (int l = 0; l < 6; l++)
			abs_s1[l] = dneg_s1[l] ? MAG_W'(-mag_s1[l]) : mag_s1[l];
	end

	// six divider lanes
	logic [QUOT_W-1:0] quot [6];
	for (genvar l = 0; l < 6; l++) begin : g_lane
		rbst_div u_div (
			.clk    (clk),
			.en     (adv),
			.num_hi (abs_s1[l][32:17]),
			.num_lo ({abs_s1[l][16:0], 16'b0}),
			.den    (den_s1[l]),
			.quot   (quot[l])
		);
	end

	// side info delay line matching the dividers
	side_t side_dl [DIV_STAGES];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++)
				side_dl[k] <= '0;
		end else if (adv) begin
			side_dl[0] <= side_s1;
			for (int k = 1; k < DIV_STAGES; k++)
				side_dl[k] <= side_dl[k-1];
		end
	end

	side_t side_o;
	assign side_o = side_dl[DIV_STAGES-1];

	// saturate, apply sign and order each axis pair
	logic signed [31:0] tn_s2 [3];
	logic signed [31:0] tf_s2 [3];
	logic [2:0]         par_s2;
	logic               par_ok_s2;
	logic               valid_s2;
	logic signed [31:0] tn_d [3];
	logic signed [31:0] tf_d [3];

	always_comb begin
		logic signed [31:0] t [6];
		for (int l = 0; l < 6; l++) begin
			if (side_o.neg[l])
				t[l] = (side_o.ovf[l] || quot[l] > 33'h080000000) ? T_MIN
					: 32'(-quot[l]);
			else
				t[l] = (side_o.ovf[l] || quot[l] > 33'h07FFFFFFF) ? T_MAX
					: 32'(quot[l]);
		end
		for (int a = 0; a < 3; a++) begin
			tn_d[a] = (t[a] > t[a+3]) ? t[a+3] : t[a];
			tf_d[a] = (t[a] > t[a+3]) ? t[a] : t[a+3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= side_o.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tn_s2     <= tn_d;
			tf_s2     <= tf_d;
			par_s2    <= side_o.par;
			par_ok_s2 <= side_o.par_ok;
		end
	end

	// narrow the interval over the three axes
	res_t res_d;
	always_comb begin
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		lo = 32'sd0;
		hi = T_MAX;
		for (int a = 0; a < 3; a++) begin
			if (!par_s2[a]) begin
				if (tn_s2[a] > lo) lo = tn_s2[a];
				if (tf_s2[a] < hi) hi = tf_s2[a];
			end
		end
		res_d.hit            = par_ok_s2 && (lo <= hi);
		res_d.entry_distance = res_d.hit ? lo[30:0] : 31'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res <= res_d;
	end

endmodule

/* tb/sv/rbst_checker.sv */
// checker for the ray versus box slab test: predicts each result and compares
module rbst_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ray_valid,
	input  logic            ray_stall,
	input  rbst_pkg::ray_t  ray,
	input  logic            res_valid,
	input  logic            res_stall,
	input  rbst_pkg::res_t  res,
	output int              fail_count,
	output int              pending
);
	import rbst_pkg::*;

	res_t hit_queue[$];

	// (num * 2^16) / den toward zero, saturated to 32 bits signed
	function automatic longint plane_param(longint num, longint den);
		bit neg;
		longint unsigned n, d, q;
		begin
			neg = (num < 0) != (den < 0);
			n = longint'(num < 0 ? -num : num) * 65536;
			d = longint'(den < 0 ? -den : den);
			q = n / d;
			if (neg) begin
				if (q > 64'd2147483648) return -64'sd2147483648;
				return -longint'(q);
			end
			if (q > 64'd2147483647) return 64'sd2147483647;
			return longint'(q);
		end
	endfunction

	// slab test over x, y, z
	function automatic res_t slab_result(ray_t r);
		longint t_lo, t_hi, o, d, mn, mx, t0, t1, tmp;
		bit hit;
		res_t out;
		begin
			t_lo = 0;
			t_hi = 64'sd2147483647;
			hit = 1;
			for (int a = 0; a < 3; a++) begin
				if (hit) begin
					case (a)
						0: begin
							o = r.origin_x; d = r.dir_x; mn = r.box_min_x; mx = r.box_max_x;
						end
						1: begin
							o = r.origin_y; d = r.dir_y; mn = r.box_min_y; mx = r.box_max_y;
						end
						default: begin
							o = r.origin_z; d = r.dir_z; mn = r.box_min_z; mx = r.box_max_z;
						end
					endcase
					if (d == 0) begin
						if (o < mn || o > mx) hit = 0;
					end else begin
						t0 = plane_param(mn - o, d);
						t1 = plane_param(mx - o, d);
						if (t0 > t1) begin
							tmp = t0;
							t0 = t1;
							t1 = tmp;
						end
						if (t0 > t_lo) t_lo = t0;
						if (t1 < t_hi) t_hi = t1;
						if (t_lo > t_hi) hit = 0;
					end
				end
			end
			out.hit = hit;
			out.entry_distance = hit ? t_lo[30:0] : '0;
			return out;
		end
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			hit_queue.delete();
		end else begin
			if (ray_valid && !ray_stall) hit_queue = {hit_queue, slab_result(ray)};
			if (res_valid && !res_stall) begin
				if (hit_queue.size() == 0) begin
					$error("result with no request outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = hit_queue.pop_front();
					if (want.hit !== res.hit || want.entry_distance !== res.entry_distance) begin
						if (want.hit !== res.hit)
							$error("hit: expected %0d actual %0d", want.hit, res.hit);
						if (want.entry_distance !== res.entry_distance)
							$error("entry_distance: expected %0h actual %0h",
								want.entry_distance, res.entry_distance);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= hit_queue.size();
		end
	end
endmodule

/* tb/sv/tb_ray_box_slab_test.sv */
// testbench top for the ray versus box slab test: stimulus and verdict
module tb_ray_box_slab_test;
	import rbst_pkg::*;

	logic clk, arst_n, ray_valid, ray_stall, res_valid, res_stall;
	ray_t ray;
	res_t res;
	int fail_count, pending;

	ray_box_slab_test i_dut (.clk, .arst_n, .ray_valid, .ray_stall, .ray,
		.res_valid, .res_stall, .res);
	rbst_checker i_chk (.clk, .arst_n, .ray_valid, .ray_stall, .ray,
		.res_valid, .res_stall, .res, .fail_count, .pending);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// overall limit
	initial begin
		#2000000;
		$display("ray_box_slab_test test failed");
		$finish;
	end

	function automatic logic [31:0] pick_val(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'h80000000;
			2: return 32'h7FFFFFFF;
			3: return 32'h0;
			4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
			default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
		endcase
	endfunction

	// mostly sane rays aimed near a box
	function automatic ray_t rand_ray();
		ray_t r;
		logic [31:0] c, s, v[12];
		int m;
		m = $urandom_range(0, 3);
		for (int i = 0; i < 12; i++) v[i] = pick_val($urandom_range(0, 5));
		if (m != 0) begin
			for (int i = 0; i < 3; i++) begin
				c = {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
				s = 32'($urandom_range(0, 32'h80000));
				v[6 + i] = c - s;
				v[9 + i] = c + s;
				v[i] = c + {{10{$urandom_range(0, 1) == 1}}, 22'($urandom)};
				v[3 + i] = ($urandom_range(0, 5) == 0) ? 32'h0 : (c - v[i]) +
					{{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
			end
		end
		r = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
		return r;
	endfunction

	task automatic send_ray(ray_t r);
		repeat ($urandom_range(0, 6)) begin
			ray_valid <= 0;
			@(negedge clk);
		end
		ray <= r;
		ray_valid <= 1;
		@(posedge clk);
		while (ray_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls at random before taking each result
	initial begin
		int w;
		res_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = $urandom_range(0, 6);
			if (w > 0) begin
				res_stall <= 1;
				repeat (w) @(negedge clk);
			end
			res_stall <= 0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		ray_t r;
		int n;
		arst_n = 0;
		ray_valid = 0;
		ray = '0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: extremes, parallel inside and outside, bound edges, inverted box
		send_ray('0);
		send_ray('1);
		send_ray({12{32'h80000000}});
		send_ray({12{32'h7FFFFFFF}});
		send_ray({32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h50000, 32'hFFFF0000,
			32'hFFFF0000, 32'h60000, 32'h10000, 32'h10000});
		send_ray({32'h0, 32'h20000, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h50000, 32'hFFFF0000,
			32'hFFFF0000, 32'h60000, 32'h10000, 32'h10000});
		send_ray({32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000,
			32'h0, 32'h0, 32'h10000, 32'h0});
		send_ray({32'h0, 32'h0, 32'h0, 32'hFFFF0000, 32'h1, 32'h1, 32'hFFFB0000, 32'h0,
			32'h0, 32'hFFFA0000, 32'h1, 32'h1});
		send_ray({32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1, 32'h7FFFFFFF, 32'h10,
			32'h10, 32'h80000000, 32'h20, 32'h20});
		send_ray({32'h80000000, 32'h0, 32'h0, 32'h1, 32'h10000, 32'h10000,
			32'h7FFFFFFF, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h10000, 32'h10000});
		send_ray({32'h7FFFFFFF, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h10000, 32'h10000,
			32'h80000000, 32'h0, 32'h0, 32'h80000000, 32'h10000, 32'h10000});
		send_ray({32'h0, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h1,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF});
		send_ray({32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h10000, 32'h0, 32'h0});
		// hold off until the pipeline has drained
		ray_valid <= 0;
		while (pending != 0) @(negedge clk);
		n = 0;
		while (n < 450) begin
			r = rand_ray();
			send_ray(r);
			n++;
			if (n == 200) begin
				ray_valid <= 0;
				while (pending != 0) @(negedge clk);
			end
		end
		ray_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ray_box_slab_test test passed");
		else
			$display("ray_box_slab_test test failed");
		$finish;
	end
endmodule
